@@ rtl/core/tprs_pkg.sv @@
`timescale 1ns / 1ps
package tprs_pkg;

  localparam int CH_W     = 2;
  localparam int IDX_W    = 4;
  localparam int MIN_W    = 11;
  localparam int LVL_W    = 8;
  localparam int CNT_W    = 5;
  localparam int ADDR_W   = CH_W + IDX_W;
  localparam int STORE_N  = 64;
  localparam int NUM_W    = 19;
  localparam int STEP_W   = 5;
  localparam int CH_MAX   = 4;
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int MIN_PER_HOUR = 60;
  localparam int LVL_MAX  = 255;

  typedef struct packed {
    logic             tick;
    logic [CH_W-1:0]  ch;
    logic [IDX_W-1:0] idx;
    logic             fin;
    logic [MIN_W-1:0] mins;
    logic [LVL_W-1:0] lvl;
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [LVL_W-1:0] duty;
    logic             last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHAN,
    S_PREV,
    S_CUR,
    S_EVAL,
    S_DIV,
    S_QUOT,
    S_RES,
    S_FLUSH
  } eng_state_e;

endpackage

@@ rtl/core/tprs_fifo.sv @@
`timescale 1ns / 1ps
module tprs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) fill_q <= fill_q + 1'b1;
      else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

@@ rtl/core/tprs_front.sv @@
`timescale 1ns / 1ps
module tprs_front import tprs_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int POINTS_PER_CHANNEL = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             opcode_i,
  input  logic [CH_W-1:0]  channel_i,
  input  logic [IDX_W-1:0] point_index_i,
  input  logic             final_point_i,
  input  logic [4:0]       hour_i,
  input  logic [5:0]       minute_i,
  input  logic [LVL_W-1:0] level_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_pop_i
);

  cmd_t cmd;
  logic keep, cmd_empty;

  always_comb begin
    cmd.tick = opcode_i;
    cmd.ch   = channel_i;
    cmd.idx  = point_index_i;
    cmd.fin  = final_point_i;
    cmd.mins = MIN_W'(hour_i) * MIN_W'(MIN_PER_HOUR) + MIN_W'(minute_i);
    cmd.lvl  = level_i;
  end

  // drop loads aimed past the configured channels or points
  assign keep = opcode_i ||
                ((int'(channel_i) < CHANNELS) && (int'(point_index_i) < POINTS_PER_CHANNEL));

  tprs_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && keep),
    .wdata_i (cmd),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

@@ rtl/core/tprs_engine.sv @@
`timescale 1ns / 1ps
module tprs_engine import tprs_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int POINTS_PER_CHANNEL = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic out_full_i,
  output logic out_push_o,
  output res_t out_o
);

  eng_state_e state_q, state_d;

  logic [CH_W:0]      ch_q;
  logic [IDX_W-1:0]   k_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   count_q [CH_MAX];
  logic [MIN_W-1:0]   now_q, prev_min_q, cur_min_q;
  logic [LVL_W-1:0]   prev_lvl_q, cur_lvl_q, last_q, duty_q;
  logic               neg_q;
  logic [NUM_W-1:0]   dvd_q;
  logic [MIN_W-1:0]   den_q;
  logic [MIN_W:0]     rem_q;
  logic [STEP_W-1:0]  step_q;
  res_t               pend_q;
  logic               pend_vld_q;
  logic [STORE_N-1:0] ldv_q;

  logic [MIN_W+LVL_W-1:0] pt_mem [STORE_N];
  logic [LVL_W-1:0]       ld_mem [STORE_N];
  logic [MIN_W+LVL_W-1:0] pt_rd_q;
  logic [LVL_W-1:0]       ld_rd_q;
  logic                   ldv_rd_q;

  logic [CH_W-1:0]   ch_lo;
  logic [ADDR_W-1:0] pt_raddr, ld_raddr, load_addr, slot;
  logic [CNT_W-1:0]  cnt_cur;
  logic              chan_done, adv_more, in_range, emit, res_stall, flush_stall;
  logic [MIN_W-1:0]  len, elapsed;
  logic [LVL_W:0]    diff;
  logic [LVL_W-1:0]  mag;
  logic [NUM_W-1:0]  product;
  logic [MIN_W:0]    rem_sh;
  logic              ge;
  logic [LVL_W:0]    qm;
  logic [LVL_W+1:0]  q_s, d_s;
  logic [LVL_W-1:0]  duty_new;

  assign ch_lo     = ch_q[CH_W-1:0];
  assign cnt_cur   = count_q[ch_lo];
  assign chan_done = (ch_q == (CH_W+1)'(CHANNELS));
  assign adv_more  = ({1'b0, k_q} + CNT_W'(2)) < cnt_q;
  assign in_range  = (now_q >= prev_min_q) && (now_q <= cur_min_q);
  assign len       = cur_min_q - prev_min_q;
  assign elapsed   = now_q - prev_min_q;
  assign diff      = {1'b0, cur_lvl_q} - {1'b0, prev_lvl_q};
  assign mag       = diff[LVL_W] ? LVL_W'(-diff) : diff[LVL_W-1:0];
  assign product   = NUM_W'(mag) * NUM_W'(elapsed);
  assign rem_sh    = {rem_q[MIN_W-1:0], dvd_q[NUM_W-1]};
  assign ge        = rem_sh >= {1'b0, den_q};
  assign emit      = duty_q != last_q;
  assign res_stall = emit && pend_vld_q && out_full_i;
  assign flush_stall = pend_vld_q && out_full_i;
  assign load_addr = {cmd_i.ch, cmd_i.idx};
  assign slot      = {ch_lo, k_q};

  // floor division: round the magnitude up when negative with a remainder
  always_comb begin
    qm       = dvd_q[LVL_W:0] + (LVL_W+1)'(rem_q != '0);
    q_s      = neg_q ? -{1'b0, qm} : {1'b0, qm};
    d_s      = {2'b00, prev_lvl_q} + q_s;
    if (d_s[LVL_W+1])       duty_new = '0;
    else if (d_s[LVL_W])    duty_new = LVL_W'(LVL_MAX);
    else                    duty_new = d_s[LVL_W-1:0];
    if (!neg_q) begin
      q_s = {1'b0, dvd_q[LVL_W:0]};
      d_s = {2'b00, prev_lvl_q} + q_s;
      if (d_s[LVL_W]) duty_new = LVL_W'(LVL_MAX);
      else            duty_new = d_s[LVL_W-1:0];
    end
  end

  always_comb begin
    pt_raddr = {ch_lo, k_q + IDX_W'(2)};
    ld_raddr = {ch_lo, k_q + IDX_W'(1)};
    case (state_q)
      S_CHAN: begin
        pt_raddr = {ch_lo, {IDX_W{1'b0}}};
        ld_raddr = {ch_lo, {IDX_W{1'b0}}};
      end
      S_PREV: begin
        pt_raddr = {ch_lo, k_q + IDX_W'(1)};
        ld_raddr = slot;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (cmd_valid_i && cmd_i.tick) state_d = S_CHAN;
      S_CHAN: begin
        if (chan_done) state_d = S_FLUSH;
        else if (cnt_cur >= CNT_W'(2)) state_d = S_PREV;
      end
      S_PREV:  state_d = S_CUR;
      S_CUR:   state_d = S_EVAL;
      S_EVAL: begin
        if (!in_range) state_d = adv_more ? S_CUR : S_CHAN;
        else if (len == '0) state_d = S_RES;
        else state_d = S_DIV;
      end
      S_DIV:   if (step_q == STEP_W'(NUM_W - 1)) state_d = S_QUOT;
      S_QUOT:  state_d = S_RES;
      S_RES:   if (!res_stall) state_d = adv_more ? S_CUR : S_CHAN;
      S_FLUSH: if (!flush_stall) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_o      = pend_q;
    case (state_q)
      S_IDLE:  cmd_pop_o = cmd_valid_i;
      S_RES:   out_push_o = emit && pend_vld_q && !out_full_i;
      S_FLUSH: begin
        out_push_o = pend_vld_q && !out_full_i;
        out_o.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ch_q       <= '0;
      k_q        <= '0;
      step_q     <= '0;
      pend_vld_q <= 1'b0;
      ldv_q      <= '0;
      for (int i = 0; i < CH_MAX; i++) count_q[i] <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.tick) begin
              ch_q <= '0;
            end else begin
              ldv_q[load_addr] <= 1'b0;
              if (cmd_i.fin) count_q[cmd_i.ch] <= CNT_W'(cmd_i.idx) + CNT_W'(1);
            end
          end
        end
        S_CHAN: begin
          if (!chan_done) begin
            if (cnt_cur < CNT_W'(2)) ch_q <= ch_q + 1'b1;
            else k_q <= '0;
          end
        end
        S_EVAL: begin
          step_q <= '0;
          if (!in_range) begin
            if (adv_more) k_q <= k_q + 1'b1;
            else ch_q <= ch_q + 1'b1;
          end
        end
        S_DIV: step_q <= step_q + 1'b1;
        S_RES: begin
          if (!res_stall) begin
            if (emit) begin
              ldv_q[slot] <= 1'b1;
              pend_vld_q  <= 1'b1;
            end
            if (adv_more) k_q <= k_q + 1'b1;
            else ch_q <= ch_q + 1'b1;
          end
        end
        S_FLUSH: if (!flush_stall) pend_vld_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pt_rd_q  <= pt_mem[pt_raddr];
    ld_rd_q  <= ld_mem[ld_raddr];
    ldv_rd_q <= ldv_q[ld_raddr];
    if (state_q == S_IDLE && cmd_valid_i && !cmd_i.tick) begin
      pt_mem[load_addr] <= {cmd_i.mins, cmd_i.lvl};
    end
    if (state_q == S_RES && !res_stall && emit) begin
      ld_mem[slot] <= duty_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (cmd_valid_i && cmd_i.tick) now_q <= cmd_i.mins;
      S_CHAN: cnt_q <= cnt_cur;
      S_PREV: {prev_min_q, prev_lvl_q} <= pt_rd_q;
      S_CUR: begin
        {cur_min_q, cur_lvl_q} <= pt_rd_q;
        last_q <= ldv_rd_q ? ld_rd_q : '0;
      end
      S_EVAL: begin
        if (!in_range) begin
          prev_min_q <= cur_min_q;
          prev_lvl_q <= cur_lvl_q;
        end else if (len == '0) begin
          duty_q <= prev_lvl_q;
        end
        neg_q <= diff[LVL_W];
        dvd_q <= product;
        den_q <= len;
        rem_q <= '0;
      end
      S_DIV: begin
        dvd_q <= {dvd_q[NUM_W-2:0], ge};
        rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
      end
      S_QUOT: duty_q <= duty_new;
      S_RES: begin
        if (!res_stall) begin
          if (emit) pend_q <= '{ch: ch_lo, duty: duty_q, last: 1'b0};
          prev_min_q <= cur_min_q;
          prev_lvl_q <= cur_lvl_q;
        end
      end
      default: ;
    endcase
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result transfer into a full queue");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (step_q < STEP_W'(NUM_W)))
    else $error("divider ran past its step count");

  a_pend_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && state_q == S_RES) |=> pend_vld_q)
    else $error("pending result lost after transfer");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && state_q == S_FLUSH) |=> (!pend_vld_q && state_q == S_IDLE))
    else $error("final result not retired");

endmodule

@@ rtl/core/timed_pwm_ramp_scheduler_top.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// -------   ---  ------------  -----------------------------------------------
// items     in   push / full   opcode, channel, point_index, final_point,
//                              hour, minute, level
// results   out  empty / pop   out_channel, duty, last_of_run
//
// The engine takes a load from idle. A tick visits each channel, reads the first
// point of each channel with two or more points, reads and checks each segment,
// and for a segment whose range holds the time runs the 19-step serial divider
// in the engine (no division if its length is zero).
// rst_ni clears the point counts and the last-sent valid bits at once.
// Four-deep item and result queues decouple both sides; the engine holds
// while it has a result to send and the result queue is full.
module timed_pwm_ramp_scheduler_top import tprs_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int POINTS_PER_CHANNEL = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             opcode_i,
  input  logic [CH_W-1:0]  channel_i,
  input  logic [IDX_W-1:0] point_index_i,
  input  logic             final_point_i,
  input  logic [4:0]       hour_i,
  input  logic [5:0]       minute_i,
  input  logic [LVL_W-1:0] level_i,
  output logic             empty,
  input  logic             pop,
  output logic [CH_W-1:0]  out_channel_o,
  output logic [LVL_W-1:0] duty_o,
  output logic             last_of_run_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop, out_full, out_push;
  res_t res_in, res_out;

  tprs_front #(
    .CHANNELS           (CHANNELS),
    .POINTS_PER_CHANNEL (POINTS_PER_CHANNEL)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode_i),
    .channel_i     (channel_i),
    .point_index_i (point_index_i),
    .final_point_i (final_point_i),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .level_i       (level_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  tprs_engine #(
    .CHANNELS           (CHANNELS),
    .POINTS_PER_CHANNEL (POINTS_PER_CHANNEL)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_o       (res_in)
  );

  tprs_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (res_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign out_channel_o = res_out.ch;
  assign duty_o        = res_out.duty;
  assign last_of_run_o = res_out.last;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import tprs_pkg::*;

  typedef struct {
    logic       op;
    logic [1:0] ch;
    logic [3:0] idx;
    logic       fin;
    logic [4:0] hr;
    logic [5:0] mn;
    logic [7:0] lvl;
  } sched_item_t;

  typedef struct {
    logic [1:0] ch;
    logic [7:0] duty;
    logic       last;
  } duty_change_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  logic clk_i, rst_ni;
  logic push, full, empty, pop;
  logic opcode_i, final_point_i, last_of_run_o;
  logic [1:0] channel_i, out_channel_o;
  logic [3:0] point_index_i;
  logic [4:0] hour_i;
  logic [5:0] minute_i;
  logic [7:0] level_i, duty_o;

  timed_pwm_ramp_scheduler_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .opcode_i(opcode_i), .channel_i(channel_i), .point_index_i(point_index_i),
    .final_point_i(final_point_i), .hour_i(hour_i), .minute_i(minute_i),
    .level_i(level_i), .empty(empty), .pop(pop), .out_channel_o(out_channel_o),
    .duty_o(duty_o), .last_of_run_o(last_of_run_o)
  );

  // predictor state
  logic [10:0] pt_mins [64];
  logic [7:0]  pt_lvl [64];
  logic [7:0]  seg_sent [64];
  logic [4:0]  pt_count [4];
  bit          pt_loaded [64];

  sched_item_t  pending_items[$];
  duty_change_t expected_duties[$];
  int  errors = 0;
  int  n_ticks = 0, n_results = 0;
  bit  stim_done = 0;
  int  hold_off = 0;

  function automatic logic [7:0] ramp_duty(int now, int slot);
    int t0, t1, l0, l1, len, num, q;
    t0 = pt_mins[slot]; t1 = pt_mins[slot+1];
    l0 = pt_lvl[slot]; l1 = pt_lvl[slot+1];
    len = t1 - t0;
    if (len <= 0) return l0[7:0];
    num = (l1 - l0) * (now - t0);
    q = num / len;
    if (num < 0 && (num % len) != 0) q -= 1;
    q = l0 + q;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  task automatic apply_item(sched_item_t it);
    int now, slot, first;
    logic [7:0] d;
    duty_change_t r;
    now = it.hr * 60 + it.mn;
    if (it.op == OP_LOAD) begin
      slot = it.ch * 16 + it.idx;
      pt_mins[slot] = now[10:0];
      pt_lvl[slot] = it.lvl;
      seg_sent[slot] = '0;
      pt_loaded[slot] = 1'b1;
      if (it.fin) pt_count[it.ch] = 5'(it.idx) + 5'd1;
      return;
    end
    n_ticks++;
    first = expected_duties.size();
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k + 1 < pt_count[c]; k++) begin
        slot = c * 16 + k;
        if (now < pt_mins[slot] || now > pt_mins[slot+1]) continue;
        d = ramp_duty(now, slot);
        if (d != seg_sent[slot]) begin
          seg_sent[slot] = d;
          r.ch = c[1:0]; r.duty = d; r.last = 1'b0;
          expected_duties.push_back(r);
        end
      end
    end
    if (expected_duties.size() > first) expected_duties[$].last = 1'b1;
  endtask

  // a tick is only safe if every point below each count has been loaded
  function automatic bit tick_safe();
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < pt_count[c]; k++)
        if (!pt_loaded[c*16+k]) return 0;
    return 1;
  endfunction

  // generation-side shadow of which points/counts exist
  bit       gen_loaded [64];
  int       gen_count [4];

  function automatic sched_item_t mk_load(int ch, int idx, bit fin, int hr, int mn,
                                          int lvl);
    sched_item_t it;
    it.op = OP_LOAD; it.ch = 2'(ch); it.idx = 4'(idx); it.fin = fin;
    it.hr = 5'(hr); it.mn = 6'(mn); it.lvl = 8'(lvl);
    return it;
  endfunction

  function automatic bit gen_tick_ok();
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < gen_count[c]; k++)
        if (!gen_loaded[c*16+k]) return 0;
    return 1;
  endfunction

  task automatic queue_item(sched_item_t it);
    if (it.op == OP_LOAD) begin
      gen_loaded[it.ch*16+it.idx] = 1;
      if (it.fin) gen_count[it.ch] = it.idx + 1;
    end else if (!gen_tick_ok()) begin
      return;
    end
    pending_items.push_back(it);
  endtask

  task automatic queue_tick(int hr, int mn);
    sched_item_t it;
    it.op = OP_TICK; it.ch = 2'($urandom); it.idx = 4'($urandom); it.fin = 1'($urandom);
    it.hr = 5'(hr); it.mn = 6'(mn); it.lvl = 8'($urandom);
    queue_item(it);
  endtask

  // well-formed schedule for one channel: non-decreasing times, random levels
  task automatic queue_schedule(int ch, int npts);
    int t;
    t = $urandom_range(0, 300);
    for (int k = 0; k < npts; k++) begin
      queue_item(mk_load(ch, k, k == npts - 1, t / 60, t % 60, $urandom_range(0, 255)));
      t += $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200);
      if (t > 1439) t = 1439;
    end
  endtask

  task automatic it_drive(sched_item_t it);
    opcode_i <= it.op; channel_i <= it.ch; point_index_i <= it.idx;
    final_point_i <= it.fin; hour_i <= it.hr; minute_i <= it.mn; level_i <= it.lvl;
  endtask

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
  end

  // stimulus
  initial begin
    int t;
    // directed: tick with no points, extremes, flat/zero-length, shared boundary
    queue_tick(0, 0);
    queue_item(mk_load(0, 0, 0, 0, 0, 0));
    queue_item(mk_load(0, 1, 0, 1, 0, 255));
    queue_item(mk_load(0, 2, 1, 1, 0, 10));         // zero-length segment
    queue_tick(0, 30);
    queue_tick(1, 0);                                // shared boundary
    queue_tick(1, 0);                                // no change
    queue_item(mk_load(1, 0, 0, 2, 0, 255));
    queue_item(mk_load(1, 15, 0, 3, 0, 0));
    for (int k = 1; k < 15; k++)
      queue_item(mk_load(1, k, k == 14, 2 + (k / 2), (k % 2) * 59, 255 - k * 17));
    queue_item(mk_load(1, 15, 1, 31, 63, 0));        // out of range time
    queue_item(mk_load(2, 0, 0, 10, 0, 100));
    queue_item(mk_load(2, 1, 1, 5, 0, 200));         // decreasing times
    queue_item(mk_load(3, 0, 1, 23, 59, 77));        // single point
    queue_tick(2, 30);
    queue_tick(31, 63);
    queue_tick(7, 0);
    queue_tick(23, 59);
    // random: well-formed schedules and tick sweeps, mixed with random loads and ticks
    while (pending_items.size() < 370) begin
      case ($urandom_range(0, 9))
        0, 1, 2: queue_schedule($urandom_range(0, 3), $urandom_range(2, 16));
        3: queue_item(mk_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        4: queue_tick($urandom, $urandom);
        default: begin
          t = $urandom_range(0, 1500);
          repeat ($urandom_range(3, 10)) begin
            queue_tick(t / 60, t % 60);
            t += $urandom_range(0, 40);
          end
        end
      endcase
    end
  end

  // driver
  int send_gap = 0;
  int sent = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 0; opcode_i <= 0; channel_i <= 0; point_index_i <= 0;
      final_point_i <= 0; hour_i <= 0; minute_i <= 0; level_i <= 0;
    end else begin
      if (push && !full) begin
        apply_item(pending_items.pop_front());
        sent++;
      end
      if ((push && !full) || !push) begin
        if (send_gap > 0 || pending_items.size() == 0) begin
          push <= 0;
          if (send_gap > 0) send_gap--;
        end else begin
          it_drive(pending_items[0]);
          push <= 1;
          send_gap = (sent % 50 < 15) ? 0 : $urandom_range(0, 16);
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;
  int recv_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    duty_change_t e;
    if (!rst_ni) begin
      pop <= 0;
      hold_off = 400;
    end else begin
      if (pop && !empty) begin
        n_results++;
        recv_cnt++;
        if (expected_duties.size() == 0) begin
          $display("%0t: unexpected transfer ch=%0d duty=%0d last=%0b", $time,
                   out_channel_o, duty_o, last_of_run_o);
          errors++;
        end else begin
          e = expected_duties.pop_front();
          if (e.ch !== out_channel_o || e.duty !== duty_o || e.last !== last_of_run_o) begin
            $display("%0t: mismatch expected ch=%0d duty=%0d last=%0b, got ch=%0d duty=%0d last=%0b",
                     $time, e.ch, e.duty, e.last, out_channel_o, duty_o, last_of_run_o);
            errors++;
          end
        end
        recv_gap = (recv_cnt % 40 < 10) ? 0 : $urandom_range(0, 16);
        if (recv_cnt == 30) hold_off = 3000;
      end
      if (hold_off > 0) begin
        hold_off--;
        pop <= 0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 0;
      end else begin
        pop <= 1;
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    wait (pending_items.size() == 0 && !push);
    wait (expected_duties.size() == 0);
    repeat (3000) @(posedge clk_i);
    $display("Covered %0d items: %0d ticks, %0d duty changes checked.",
             sent, n_ticks, n_results);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end
endmodule
